@@ hdl/dto_pkg.sv @@
// Shared constants for the debounced toggle occupancy block.
// Has no dependencies. The top level imports it.
`timescale 1ns / 1ps

package dto_pkg;

    // Sample timestamp and configuration field widths
    localparam int TimeW = 32;
    localparam int CfgW  = 16;

    // Button channels and width of the occupied count result
    localparam int ChanN  = 4;
    localparam int CountW = 3;

    // Configuration register index width and register map
    localparam int CfgIdxW = 8;
    localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE = 8'd0;
    localparam logic [CfgIdxW-1:0] CFG_SETTLE   = 8'd1;

    // Register values after reset
    localparam logic [CfgW-1:0] DEBOUNCE_RST = 16'd50;
    localparam logic [CfgW-1:0] SETTLE_RST   = 16'd200;

endpackage

@@ hdl/debounced_toggle_occupancy.sv @@
// Top level of the debounced toggle occupancy monitor.
// Depends on dto_pkg for widths, register map and reset values.
`timescale 1ns / 1ps

// One sample request (timestamp plus raw button levels) is taken per clock
// while o_in_stall is low, and its result is registered. The first sample
// after reset records boot time; samples until settle_ms has elapsed reload
// the baseline, and the sample that finds the interval passed raises armed.
// After that each channel is debounced: a stable rising edge held quiet
// longer than debounce_ms toggles that space's occupied flag. A two-deep
// result buffer lets a new sample in while an earlier result is stalled;
// o_in_stall rises only when both are full.
// Configuration writes are always ready and should be made while idle.
module debounced_toggle_occupancy
    import dto_pkg::*;
(
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [CfgIdxW-1:0]                i_cfg_index,
    input  logic [CfgW-1:0]                   i_cfg_data,
    // sample channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [TimeW-1:0]                  i_now_ms,
    input  logic [ChanN-1:0]                  i_button_levels,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [ChanN-1:0]                  o_occupied_mask,
    output logic [CountW-1:0]                 o_occupied_count,
    output logic                              o_changed,
    output logic                              o_armed
);

    // Configuration registers
    logic [CfgW-1:0] r_debounce_ms;
    logic [CfgW-1:0] r_settle_ms;

    // Monitor state
    logic                  r_boot_seen, n_boot_seen;
    logic [TimeW-1:0]      r_boot_time, n_boot_time;
    logic                  r_is_armed, n_is_armed;
    logic [ChanN-1:0]      r_prev_raw, n_prev_raw;
    logic [ChanN-1:0]      r_stable, n_stable;
    logic [ChanN-1:0]      r_flags, n_flags;
    logic [TimeW-1:0]      r_change_time [ChanN];
    logic [TimeW-1:0]      n_change_time [ChanN];
    logic [TimeW-1:0]      w_age [ChanN];
    logic                  n_changed;
    logic [CountW-1:0]     n_count;
    logic [TimeW-1:0]      w_since_boot;

    // Result register and skid stage
    logic                  r_out_valid;
    logic [ChanN-1:0]      r_out_mask;
    logic [CountW-1:0]     r_out_count;
    logic                  r_out_changed;
    logic                  r_out_armed;
    logic                  r_skid_valid;
    logic [ChanN-1:0]      r_skid_mask;
    logic [CountW-1:0]     r_skid_count;
    logic                  r_skid_changed;
    logic                  r_skid_armed;

    logic w_in_acc;
    logic w_out_free;

    // Handshake
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign w_in_acc    = i_in_valid && !r_skid_valid;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ms <= DEBOUNCE_RST;
            r_settle_ms   <= SETTLE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DEBOUNCE: r_debounce_ms <= i_cfg_data;
                CFG_SETTLE:   r_settle_ms   <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    assign w_since_boot = i_now_ms - r_boot_time;

    // Next state for one sample
    always_comb begin
        n_boot_seen   = r_boot_seen;
        n_boot_time   = r_boot_time;
        n_is_armed    = r_is_armed;
        n_prev_raw    = r_prev_raw;
        n_stable      = r_stable;
        n_flags       = r_flags;
        n_changed     = 1'b0;
        n_change_time = r_change_time;
        w_age         = r_change_time;
        if (!r_boot_seen) begin
            // first sample: record boot time and baseline
            n_boot_seen = 1'b1;
            n_boot_time = i_now_ms;
            n_is_armed  = 1'b0;
            n_prev_raw  = i_button_levels;
            n_stable    = i_button_levels;
            for (int i = 0; i < ChanN; i++) begin
                n_change_time[i] = i_now_ms;
            end
        end else if (!r_is_armed) begin
            // settling: keep reloading baseline until interval passes
            n_prev_raw = i_button_levels;
            n_stable   = i_button_levels;
            for (int i = 0; i < ChanN; i++) begin
                n_change_time[i] = i_now_ms;
            end
            if (w_since_boot >= TimeW'(r_settle_ms)) begin
                n_is_armed = 1'b1;
            end
        end else begin
            // armed: per-channel debounce, rising stable edge toggles
            for (int i = 0; i < ChanN; i++) begin
                if (i_button_levels[i] != r_prev_raw[i]) begin
                    n_change_time[i] = i_now_ms;
                end
                w_age[i] = i_now_ms - n_change_time[i];
                if ((w_age[i] > TimeW'(r_debounce_ms)) &&
                    (i_button_levels[i] != r_stable[i])) begin
                    n_stable[i] = i_button_levels[i];
                    if (i_button_levels[i]) begin
                        n_flags[i] = !r_flags[i];
                        n_changed  = 1'b1;
                    end
                end
            end
            n_prev_raw = i_button_levels;
        end
    end

    // Occupied count is the number of set flags
    always_comb begin
        n_count = '0;
        for (int i = 0; i < ChanN; i++) begin
            n_count = n_count + CountW'(n_flags[i]);
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_boot_seen <= 1'b0;
            r_is_armed  <= 1'b0;
            r_flags     <= '0;
            r_boot_time <= '0;
            r_prev_raw  <= '0;
            r_stable    <= '0;
        end else if (w_in_acc) begin
            r_boot_seen <= n_boot_seen;
            r_is_armed  <= n_is_armed;
            r_flags     <= n_flags;
            r_boot_time <= n_boot_time;
            r_prev_raw  <= n_prev_raw;
            r_stable    <= n_stable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_change_time <= n_change_time;
        end
    end

    // Result register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= w_in_acc;
            end
        end else if (w_in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            if (r_skid_valid) begin
                r_out_mask    <= r_skid_mask;
                r_out_count   <= r_skid_count;
                r_out_changed <= r_skid_changed;
                r_out_armed   <= r_skid_armed;
            end else begin
                r_out_mask    <= n_flags;
                r_out_count   <= n_count;
                r_out_changed <= n_changed;
                r_out_armed   <= n_is_armed;
            end
        end else if (w_in_acc) begin
            r_skid_mask    <= n_flags;
            r_skid_count   <= n_count;
            r_skid_changed <= n_changed;
            r_skid_armed   <= n_is_armed;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_occupied_mask  = r_out_mask;
    assign o_occupied_count = r_out_count;
    assign o_changed        = r_out_changed;
    assign o_armed          = r_out_armed;

endmodule

@@ tb/debounced_toggle_occupancy_checker.sv @@
// Scoreboard for the debounced toggle occupancy monitor: watches the sample,
// result and register channels, predicts each result and compares it.
// Depends on dto_pkg for the register map, widths and reset values.
`timescale 1ns / 1ps

module debounced_toggle_occupancy_checker
    import dto_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // register write channel
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [CfgW-1:0]    i_cfg_data,
    // sample channel
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [TimeW-1:0]   i_now_ms,
    input  logic [ChanN-1:0]   i_button_levels,
    // result channel
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [ChanN-1:0]   i_occupied_mask,
    input  logic [CountW-1:0]  i_occupied_count,
    input  logic               i_changed,
    input  logic               i_armed,
    // status toward the test top
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_toggles
);

    typedef struct packed {
        logic [ChanN-1:0]  mask;
        logic [CountW-1:0] count;
        logic              changed;
        logic              armed;
    } occ_result_t;

    // Shadow copy of the registers and of the monitor state
    logic [CfgW-1:0]   quiet_ms;
    logic [CfgW-1:0]   boot_hold_ms;
    logic              boot_done;
    logic [TimeW-1:0]  boot_stamp;
    logic              armed_now;
    logic [ChanN-1:0]  last_raw;
    logic [ChanN-1:0]  settled;
    logic [TimeW-1:0]  edge_stamp [ChanN];
    logic [ChanN-1:0]  occ_flags;
    logic [CountW-1:0] occ_cnt;

    occ_result_t occ_expected_q[$];

    int fails   = 0;
    int checked = 0;
    int toggles = 0;

    // Reload every channel's baseline from one sample
    function automatic void rebase(input logic [ChanN-1:0] lev,
                                   input logic [TimeW-1:0] now);
        last_raw = lev;
        settled  = lev;
        for (int i = 0; i < ChanN; i++) edge_stamp[i] = now;
    endfunction

    // Advance the shadow state by one sample and return the result it gives
    function automatic occ_result_t track_sample(input logic [TimeW-1:0] now,
                                                 input logic [ChanN-1:0] lev);
        occ_result_t      res;
        logic             flipped;
        logic [TimeW-1:0] quiet_for;
        logic [TimeW-1:0] since_boot;
        flipped = 1'b0;
        if (!boot_done) begin
            boot_done  = 1'b1;
            rebase(lev, now);
            boot_stamp = now;
            armed_now  = 1'b0;
        end else if (!armed_now) begin
            rebase(lev, now);
            since_boot = now - boot_stamp;
            if (since_boot >= TimeW'(boot_hold_ms)) armed_now = 1'b1;
        end else begin
            for (int i = 0; i < ChanN; i++) begin
                if (lev[i] != last_raw[i]) edge_stamp[i] = now;
                quiet_for = now - edge_stamp[i];
                if (quiet_for > TimeW'(quiet_ms) && lev[i] != settled[i]) begin
                    settled[i] = lev[i];
                    // only a stable rising edge toggles the space
                    if (lev[i]) begin
                        occ_flags[i] = ~occ_flags[i];
                        occ_cnt      = occ_flags[i] ? occ_cnt + CountW'(1)
                                                    : occ_cnt - CountW'(1);
                        flipped      = 1'b1;
                    end
                end
                last_raw[i] = lev[i];
            end
        end
        res.mask    = occ_flags;
        res.count   = occ_cnt;
        res.changed = flipped;
        res.armed   = armed_now;
        return res;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            fails++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : track
        occ_result_t want;
        if (!i_rst_n) begin
            quiet_ms     = DEBOUNCE_RST;
            boot_hold_ms = SETTLE_RST;
            boot_done    = 1'b0;
            boot_stamp   = '0;
            armed_now    = 1'b0;
            last_raw     = '0;
            settled      = '0;
            for (int i = 0; i < ChanN; i++) edge_stamp[i] = '0;
            occ_flags    = '0;
            occ_cnt      = '0;
            occ_expected_q.delete();
        end else begin
            // register writes; unknown indexes leave everything as it was
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DEBOUNCE: quiet_ms     = i_cfg_data;
                    CFG_SETTLE:   boot_hold_ms = i_cfg_data;
                    default: ;
                endcase
            end
            // compare before queuing, so a stray result cannot match a fresh sample
            if (i_out_valid && !i_out_stall) begin
                if (occ_expected_q.size() == 0) begin
                    fails++;
                    $display("%0t ns: result with no sample pending, %s %b",
                             $time, "expected none, actual mask", i_occupied_mask);
                end else begin
                    want = occ_expected_q.pop_front();
                    check_field("occupied_mask", want.mask, i_occupied_mask);
                    check_field("occupied_count", want.count, i_occupied_count);
                    check_field("changed", want.changed, i_changed);
                    check_field("armed", want.armed, i_armed);
                    checked++;
                    if (want.changed) toggles++;
                end
            end
            if (i_in_valid && !i_in_stall)
                occ_expected_q.push_back(track_sample(i_now_ms, i_button_levels));
        end
        o_fail_count <= fails;
        o_pending    <= occ_expected_q.size();
        o_checked    <= checked;
        o_toggles    <= toggles;
    end

endmodule

@@ tb/debounced_toggle_occupancy_tb.sv @@
// Test top for the debounced toggle occupancy monitor: clock, reset, sample
// and register requests, random stalls, watchdog and verdict.
// Depends on dto_pkg, the block and debounced_toggle_occupancy_checker.
`timescale 1ns / 1ps

module debounced_toggle_occupancy_tb;
    import dto_pkg::*;

    localparam int QuietLimit  = 2000;
    localparam int PhaseItems  = 175;
    localparam int RandPhases  = 6;

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_cfg_valid     = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_index     = '0;
    logic [CfgW-1:0]    i_cfg_data      = '0;
    logic               i_in_valid      = 1'b0;
    logic [TimeW-1:0]   i_now_ms        = '0;
    logic [ChanN-1:0]   i_button_levels = '0;
    logic               i_out_stall     = 1'b0;
    logic               o_cfg_ready;
    logic               o_in_stall;
    logic               o_out_valid;
    logic [ChanN-1:0]   o_occupied_mask;
    logic [CountW-1:0]  o_occupied_count;
    logic               o_changed;
    logic               o_armed;

    int fail_count;
    int pending;
    int checked;
    int toggles;

    // idling controls, changed per phase
    logic calm      = 1'b0;
    int   gap_pct   = 25;
    int   stall_pct = 25;
    int   quiet_cycles = 0;
    int   settings_run = 0;

    debounced_toggle_occupancy uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_now_ms         (i_now_ms),
        .i_button_levels  (i_button_levels),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_occupied_mask  (o_occupied_mask),
        .o_occupied_count (o_occupied_count),
        .o_changed        (o_changed),
        .o_armed          (o_armed)
    );

    debounced_toggle_occupancy_checker chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_now_ms         (i_now_ms),
        .i_button_levels  (i_button_levels),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_occupied_mask  (o_occupied_mask),
        .i_occupied_count (o_occupied_count),
        .i_changed        (o_changed),
        .i_armed          (o_armed),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked),
        .o_toggles        (toggles)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Result side back-pressure, switched on and off at random unless calm is set
    initial begin : stall_gen
        int n;
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 99) < stall_pct) begin
                n = $urandom_range(1, 6);
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            n = $urandom_range(1, 12);
            i_out_stall <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    end

    // Watchdog: too long without any request moving ends the run
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QuietLimit) begin
            $display("%0t ns: no request moved for %0d cycles", $time, QuietLimit);
            $display("debounced_toggle_occupancy regression: fail");
            $finish;
        end
    end

    // Register write request; valid stays high for a following write
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Sample request with an optional random gap ahead of it
    task automatic send_sample(input logic [TimeW-1:0] now, input logic [ChanN-1:0] lev);
        int gap;
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_now_ms        <= now;
        i_button_levels <= lev;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Stop sending and let every outstanding result drain
    task automatic drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [TimeW-1:0] t;
        logic [TimeW-1:0] clock_ms;
        logic [ChanN-1:0] lev;
        logic [CfgW-1:0]  quiet;
        int               span;
        int               pick;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // longest settle window, plus writes to indexes that do not exist
        write_reg(CFG_SETTLE, 16'hFFFF);
        write_reg(8'hFF, 16'h0000);
        write_reg(8'd2, 16'hFFFF);
        i_cfg_valid <= 1'b0;
        settings_run++;

        // boot near the top of the time range, arming after the wrap
        send_sample(32'hFFFF_F000, 4'b1010);
        send_sample(32'hFFFF_F001, 4'b0101);
        send_sample(32'h0000_EFFE, 4'b0000);   // one ms short of settle
        send_sample(32'h0000_EFFF, 4'b0000);   // arming sample
        // default quiet time: exactly 50 ms does not pass, 51 does
        t = 32'h0000_F000;
        send_sample(t, 4'b1111);
        send_sample(t + 50, 4'b1111);
        send_sample(t + 51, 4'b1111);
        // falling stable edge leaves the flags alone
        send_sample(t + 60, 4'b0000);
        send_sample(t + 120, 4'b0000);
        // bounce on space 1, clean rise on space 0 toggles it off
        send_sample(t + 121, 4'b0011);
        send_sample(t + 130, 4'b0001);
        send_sample(t + 200, 4'b0001);
        // quiet time measured across the timestamp wrap, then a step back
        send_sample(32'hFFFF_FFFF, 4'b1000);
        send_sample(32'h0000_0040, 4'b1000);
        send_sample(32'h0000_0000, 4'b1000);

        // zero quiet time: any later sample accepts the level
        drain();
        write_reg(CFG_DEBOUNCE, 16'd0);
        write_reg(CFG_SETTLE, 16'd0);
        i_cfg_valid <= 1'b0;
        settings_run++;
        send_sample(32'd100, 4'b0100);
        send_sample(32'd100, 4'b0100);
        send_sample(32'd101, 4'b0100);

        // random phases: mostly holds and single bounces scaled to the quiet time
        clock_ms = 32'd200;
        lev      = 4'b0100;
        for (int p = 0; p < RandPhases; p++) begin
            drain();
            case (p)
                0:       quiet = 16'd0;
                1:       quiet = 16'hFFFF;
                2:       quiet = 16'd50;
                3:       quiet = 16'($urandom_range(1, 200));
                4:       quiet = 16'd3;
                default: quiet = 16'($urandom_range(0, 65535));
            endcase
            write_reg(CFG_DEBOUNCE, quiet);
            write_reg(CFG_SETTLE, (p == 1) ? 16'hFFFF : 16'($urandom));
            i_cfg_valid <= 1'b0;
            settings_run++;
            gap_pct   = $urandom_range(0, 40);
            stall_pct = $urandom_range(0, 40);
            calm      = (p == RandPhases - 1);
            span      = int'(quiet);
            for (int k = 0; k < PhaseItems; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    clock_ms = clock_ms + $urandom_range(0, span / 4 + 1);
                else if (pick < 95)
                    clock_ms = clock_ms + $urandom_range(span / 2, span * 2 + 2);
                else
                    clock_ms = $urandom;          // jump anywhere, wraps included
                pick = $urandom_range(0, 99);
                if (pick >= 93)
                    lev = ChanN'($urandom);
                else if (pick >= 75)
                    lev = lev ^ (ChanN'(1) << $urandom_range(0, ChanN - 1));
                send_sample(clock_ms, lev);
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        $display("summary: %0d samples checked over %0d register settings, %0d occupancy toggles",
                 checked, settings_run, toggles);
        $display("summary: covered boot and settle window across the wrap, bounces, holds, jumps");
        if (fail_count == 0 && pending == 0) begin
            $display("debounced_toggle_occupancy regression: pass");
        end else begin
            $display("debounced_toggle_occupancy regression: fail");
        end
        $finish;
    end

endmodule
